// ===== hw/rtl/rbd_pkg.sv =====
// rbd_pkg: types and constants shared by the ring buffer deque modules.
// No dependencies; compile first.
package rbd_pkg;

   localparam int ITEM_W  = 32;   // item width on both channels
   localparam int CAP_W   = 5;    // capacity register width
   localparam int FILL_W  = 5;    // fill count width on the result channel

   typedef enum logic [1:0] {
      FUNC_PUSH_BACK  = 2'd0,
      FUNC_PUSH_FRONT = 2'd1,
      FUNC_POP_BACK   = 2'd2,
      FUNC_POP_FRONT  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      func_type           func;
      logic [ITEM_W-1:0]  push_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [ITEM_W-1:0]  popped_value;
      logic [FILL_W-1:0]  fill_count;
      logic               is_empty;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;      // capture the request item
      logic execute;   // perform the operation, update pointers, access the slots
   } ctrl_type;

endpackage

// ===== hw/rtl/ring_buffer_deque.sv =====
// ring_buffer_deque: top level of a double-ended queue over a ring of item slots.
// Depends on rbd_pkg, rbd_ctrl, rbd_dpath (and rbd_ram through it).
//
//  channel   ports                          handshake
//  --------  -----------------------------  ------------------------------------
//  request   start, busy, req_item          item taken when start && !busy
//  result    rsp_valid, rsp_item            one-cycle strobe, cannot be held off
//  config    csr_wr_en, csr_wr_data         capacity written when csr_wr_en high
//
// Every item passes through capture, execute (pointer update plus one slot
// access on the slot store), then the result strobe once the registered
// read data is back. busy stays high from the accept to the end of the strobe,
// so the next item can be taken in the cycle after the strobe.
// Reset is synchronous: pointers and fill count go to zero, capacity to 16.
// The slot store is not cleared; slots are only read after being written.
// The receiver has no back-pressure, so nothing inside ever stalls.
//
// DEPTH is the slot store size, 2 to 31 (capacity and fill count are 5 bits).
module ring_buffer_deque import rbd_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             start,
   output logic             busy,
   input  req_type          req_item,
   // result channel
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   // capacity register
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   ctrl_type ctrl;

   // sequencing: idle -> execute -> respond
   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   // pointers, count, capacity and slots
   rbd_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_item    (rsp_item)
   );

endmodule

// ===== hw/rtl/rbd_ram.sv =====
// rbd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rbd_ctrl.sv =====
// rbd_ctrl: sequencing state machine for the ring buffer deque.
// Depends on rbd_pkg.
module rbd_ctrl import rbd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output logic     rsp_valid,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC:  state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      ctrl.load    = 1'b0;
      ctrl.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         S_EXEC:  ctrl.execute = 1'b1;
         S_RESP:  rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule

// ===== hw/rtl/rbd_dpath.sv =====
// rbd_dpath: pointers, fill count, capacity register and slot store of the deque.
// Depends on rbd_pkg and rbd_ram.
module rbd_dpath import rbd_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  ctrl_type         ctrl,
   input  req_type          req_item,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data,
   output rsp_type          rsp_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   req_type          req_ff, req_in;
   logic [PTR_W-1:0] back_ptr_ff, back_ptr_in;
   logic [PTR_W-1:0] front_ptr_ff, front_ptr_in;
   logic [CNT_W-1:0] held_ff, held_in;
   logic [CAP_W-1:0] capacity_ff, capacity_in;
   status_type       status_ff, status_in;
   logic             pop_ok_ff, pop_ok_in;

   logic [CNT_W-1:0]  cap_use;
   logic [PTR_W-1:0]  bp, fp, step_ptr;
   logic              mem_wr, mem_rd;
   logic [PTR_W-1:0]  mem_addr;
   logic [ITEM_W-1:0] mem_rd_data;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(p) + CNT_W'(1);
      return (nxt >= cap) ? '0 : PTR_W'(nxt);
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] last;
      last = cap - CNT_W'(1);
      return (p == '0) ? PTR_W'(last) : p - PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         back_ptr_ff  <= '0;
         front_ptr_ff <= '0;
         held_ff      <= '0;
         capacity_ff  <= CAP_W'(16);
      end else begin
         back_ptr_ff  <= back_ptr_in;
         front_ptr_ff <= front_ptr_in;
         held_ff      <= held_in;
         capacity_ff  <= capacity_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      pop_ok_ff <= pop_ok_in;
   end

   // capacity 0 acts as 1, anything beyond the store acts as the store size
   always_comb begin
      if (capacity_ff == '0) begin
         cap_use = CNT_W'(1);
      end else if (int'(capacity_ff) > DEPTH) begin
         cap_use = CNT_W'(DEPTH);
      end else begin
         cap_use = CNT_W'(capacity_ff);
      end
   end

   always_comb begin
      bp = (CNT_W'(back_ptr_ff)  >= cap_use) ? '0 : back_ptr_ff;
      fp = (CNT_W'(front_ptr_ff) >= cap_use) ? '0 : front_ptr_ff;

      req_in       = req_ff;
      back_ptr_in  = back_ptr_ff;
      front_ptr_in = front_ptr_ff;
      held_in      = held_ff;
      capacity_in  = capacity_ff;
      status_in    = status_ff;
      pop_ok_in    = pop_ok_ff;
      mem_wr       = 1'b0;
      mem_rd       = 1'b0;
      mem_addr     = bp;
      step_ptr     = '0;

      if (ctrl.load) begin
         req_in = req_item;
      end

      if (ctrl.execute) begin
         status_in    = ST_DONE;
         pop_ok_in    = 1'b0;
         back_ptr_in  = bp;
         front_ptr_in = fp;
         case (req_ff.func)
            FUNC_PUSH_BACK: begin
               if (held_ff < cap_use) begin
                  mem_wr      = 1'b1;
                  mem_addr    = bp;
                  back_ptr_in = ring_next(bp, cap_use);
                  held_in     = held_ff + CNT_W'(1);
               end else begin
                  status_in = ST_OVERFLOW;
               end
            end
            FUNC_PUSH_FRONT: begin
               if (held_ff < cap_use) begin
                  mem_wr = 1'b1;
                  if (held_ff != '0) begin
                     step_ptr     = ring_prev(fp, cap_use);
                     front_ptr_in = step_ptr;
                     mem_addr     = step_ptr;
                  end else begin
                     // empty queue: restart the ring at slot zero
                     front_ptr_in = '0;
                     back_ptr_in  = ring_next('0, cap_use);
                     mem_addr     = '0;
                  end
                  held_in = held_ff + CNT_W'(1);
               end else begin
                  status_in = ST_OVERFLOW;
               end
            end
            FUNC_POP_BACK: begin
               if (held_ff != '0) begin
                  step_ptr    = ring_prev(bp, cap_use);
                  back_ptr_in = step_ptr;
                  mem_addr    = step_ptr;
                  mem_rd      = 1'b1;
                  pop_ok_in   = 1'b1;
                  held_in     = held_ff - CNT_W'(1);
               end else begin
                  status_in = ST_UNDERFLOW;
               end
            end
            FUNC_POP_FRONT: begin
               if (held_ff != '0) begin
                  mem_addr     = fp;
                  mem_rd       = 1'b1;
                  front_ptr_in = ring_next(fp, cap_use);
                  pop_ok_in    = 1'b1;
                  held_in      = held_ff - CNT_W'(1);
               end else begin
                  status_in = ST_UNDERFLOW;
               end
            end
            default: status_in = ST_DONE;
         endcase
      end

      // capacity write empties the queue
      if (csr_wr_en) begin
         capacity_in  = csr_wr_data;
         back_ptr_in  = '0;
         front_ptr_in = '0;
         held_in      = '0;
      end
   end

   rbd_ram #(
      .WIDTH (ITEM_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (mem_addr),
      .wr_data (req_ff.push_value),
      .rd_en   (mem_rd),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      rsp_item.status       = status_ff;
      rsp_item.popped_value = pop_ok_ff ? mem_rd_data : '0;
      rsp_item.fill_count   = FILL_W'(held_ff);
      rsp_item.is_empty     = (held_ff == '0);
   end

endmodule

// ===== hw/rtl/rbd_chk.sv =====
// rbd_chk: port-level assertions for ring_buffer_deque, bound to the top level.
// Depends on rbd_pkg and ring_buffer_deque.
module rbd_chk import rbd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // an accepted item yields a result strobe once the execute state is over
   a_accept_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid) ##1 rsp_valid)
      else $error("result strobe not two cycles after accept");

   // block frees up right after the strobe
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (busy ##1 !busy && !rsp_valid))
      else $error("busy not released after result");

   // empty flag agrees with fill count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.is_empty == (rsp_item.fill_count == '0)))
      else $error("empty flag and fill count disagree");

   // underflow only on an empty queue and returns no item
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_UNDERFLOW)
         |-> (rsp_item.is_empty && rsp_item.popped_value == '0))
      else $error("underflow on non-empty queue or with data");

endmodule

bind ring_buffer_deque rbd_chk u_rbd_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// ===== tb/sv/tb_ring_buffer_deque.sv =====
// tb_ring_buffer_deque: self-checking testbench for the ring buffer deque.
// Depends on rbd_pkg and ring_buffer_deque; predicts every result cycle-free
// and checks them in order against what the block strobes out.
module tb_ring_buffer_deque;
   timeunit 1ns;
   timeprecision 1ps;

   import rbd_pkg::*;

   localparam int SLOTS         = 16;     // slot store depth of the instance
   localparam int SETTLE_CYCLES = 4;      // idle cycles before a capacity write or settle point
   localparam int TAIL_CYCLES   = 8;      // drain time after the last result
   localparam int CYCLE_LIMIT   = 50000;  // far above the slowest honest run
   localparam int SHOWN_MAX     = 40;     // mismatch lines printed at most

   // what the driver can be asked to do next
   typedef enum logic [1:0] {
      JOB_ITEM,      // present one request item
      JOB_SET_CAP,   // write the capacity register once the block is idle
      JOB_SETTLE     // just wait until every owed result is back
   } job_kind_type;

   typedef struct {
      job_kind_type     kind;
      req_type          item;
      logic [CAP_W-1:0] cap;
      logic             gaps;   // sender may idle before this item
   } job_type;

   // ---------------------------------------------------------------------------
   // Clock, reset and DUT
   // ---------------------------------------------------------------------------
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   req_type          req_item    = '0;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_wr_en   = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ring_buffer_deque #(.DEPTH(SLOTS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------------
   job_type jobs[$];           // pending stimulus, filled once at time zero
   rsp_type owed_results[$];   // predicted results, oldest first
   int      miss_count = 0;
   int      cycles     = 0;
   logic    all_sent   = 1'b0; // driver has nothing left to present
   logic    gaps_on    = 1'b1; // idling allowed for items queued from now on

   // ---------------------------------------------------------------------------
   // Deque predictor: own copy of the ring, pointers, fill and capacity
   // ---------------------------------------------------------------------------
   logic [ITEM_W-1:0] q_slots [SLOTS];
   int                q_back;
   int                q_front;
   int                q_held;
   logic [CAP_W-1:0]  q_cap;

   function automatic int step_fwd(input int p, input int span);
      return (p + 1 >= span) ? 0 : p + 1;
   endfunction

   function automatic int step_rev(input int p, input int span);
      return (p == 0 || p >= span) ? span - 1 : p - 1;
   endfunction

   // Applies one operation to the predicted deque and returns the result it owes.
   function automatic rsp_type apply_deque_op(input req_type r);
      rsp_type o;
      int      span;
      // capacity 0 behaves as 1, anything past the store as the full store
      span = (q_cap == 0) ? 1 : (q_cap > SLOTS) ? SLOTS : int'(q_cap);
      o.status       = ST_DONE;
      o.popped_value = '0;
      if (q_back >= span) q_back = 0;
      if (q_front >= span) q_front = 0;
      case (r.func)
         FUNC_PUSH_BACK: begin
            if (q_held < span) begin
               q_slots[q_back] = r.push_value;
               q_back = step_fwd(q_back, span);
               q_held++;
            end else begin
               o.status = ST_OVERFLOW;
            end
         end
         FUNC_PUSH_FRONT: begin
            if (q_held < span) begin
               if (q_held != 0) begin
                  q_front = step_rev(q_front, span);
                  q_held++;
               end else begin
                  // front push into an empty deque re-bases both pointers
                  q_front = 0;
                  q_back  = step_fwd(0, span);
                  q_held  = 1;
               end
               q_slots[q_front] = r.push_value;
            end else begin
               o.status = ST_OVERFLOW;
            end
         end
         FUNC_POP_BACK: begin
            if (q_held != 0) begin
               q_back = step_rev(q_back, span);
               o.popped_value = q_slots[q_back];
               q_held--;
            end else begin
               o.status = ST_UNDERFLOW;
            end
         end
         default: begin
            if (q_held != 0) begin
               o.popped_value = q_slots[q_front];
               q_front = step_fwd(q_front, span);
               q_held--;
            end else begin
               o.status = ST_UNDERFLOW;
            end
         end
      endcase
      o.fill_count = q_held[FILL_W-1:0];
      o.is_empty   = (q_held == 0);
      return o;
   endfunction

   task automatic log_miss(input string what, input logic [31:0] got,
                           input logic [31:0] want);
      miss_count++;
      if (miss_count <= SHOWN_MAX)
         $display("[cycle %0d] mismatch on %s: got %h, want %h", cycles, what, got, want);
   endtask

   // ---------------------------------------------------------------------------
   // Monitor: watches all three channels. Checking, configuration tracking and
   // prediction share one process so the owed queue is never raced.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type owed;
      if (reset) begin
         q_back  = 0;
         q_front = 0;
         q_held  = 0;
         q_cap   = CAP_W'(SLOTS);
      end else begin
         if (rsp_valid) begin
            if (owed_results.size() == 0) begin
               log_miss("result with nothing owed", rsp_item.popped_value, '0);
            end else begin
               owed = owed_results.pop_front();
               if (rsp_item.status !== owed.status)
                  log_miss("status", rsp_item.status, owed.status);
               if (rsp_item.popped_value !== owed.popped_value)
                  log_miss("popped_value", rsp_item.popped_value, owed.popped_value);
               if (rsp_item.fill_count !== owed.fill_count)
                  log_miss("fill_count", rsp_item.fill_count, owed.fill_count);
               if (rsp_item.is_empty !== owed.is_empty)
                  log_miss("is_empty", rsp_item.is_empty, owed.is_empty);
            end
         end
         // any capacity write empties the deque
         if (csr_wr_en) begin
            q_cap   = csr_wr_data;
            q_back  = 0;
            q_front = 0;
            q_held  = 0;
         end
         if (start && !busy)
            owed_results.push_back(apply_deque_op(req_item));
      end
   end

   // ---------------------------------------------------------------------------
   // Driver: one decision per edge, one nonblocking write per signal.
   // An item stays on the port until start && !busy; before an item the sender
   // may idle for a random gap. Capacity writes and settle points wait for every
   // owed result and a quiet stretch on the ports, so the block is truly idle.
   // ---------------------------------------------------------------------------
   int gap_left = 0;
   int quiet    = 0;
   bit rested   = 1'b0;   // a burst has just ended: the next item goes straight out

   always @(posedge clock) begin
      job_type          nxt;
      logic             n_start;
      logic             n_wr;
      logic             n_done;
      req_type          n_item;
      logic [CAP_W-1:0] n_cap;
      n_start = start && busy;   // an item still waiting to be taken stays up
      n_item  = req_item;
      n_wr    = 1'b0;
      n_cap   = csr_wr_data;
      n_done  = 1'b0;
      if (owed_results.size() == 0 && !start && !busy && !csr_wr_en)
         quiet++;
      else
         quiet = 0;
      if (!reset && !n_start) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (jobs.size() == 0) begin
            n_done = 1'b1;
         end else if (jobs[0].kind == JOB_ITEM) begin
            if (jobs[0].gaps && !rested && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(0, 4);
               rested   = 1'b1;
            end else begin
               nxt     = jobs.pop_front();
               n_start = 1'b1;
               n_item  = nxt.item;
               rested  = 1'b0;
            end
         end else if (quiet >= SETTLE_CYCLES) begin
            nxt   = jobs.pop_front();
            n_wr  = (nxt.kind == JOB_SET_CAP);
            n_cap = nxt.cap;
            quiet = 0;
         end
      end
      start       <= n_start;
      req_item    <= n_item;
      csr_wr_en   <= n_wr;
      csr_wr_data <= n_cap;
      all_sent    <= n_done;
   end

   // ---------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------------
   function automatic logic [ITEM_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_item(input func_type f, input logic [ITEM_W-1:0] v);
      job_type j;
      j.kind            = JOB_ITEM;
      j.item.func       = f;
      j.item.push_value = v;
      j.cap             = '0;
      j.gaps            = gaps_on;
      jobs.push_back(j);
   endtask

   task automatic queue_cap(input int c);
      job_type j;
      j.kind = JOB_SET_CAP;
      j.item = '0;
      j.cap  = c[CAP_W-1:0];
      j.gaps = gaps_on;
      jobs.push_back(j);
   endtask

   task automatic queue_settle();
      job_type j;
      j.kind = JOB_SETTLE;
      j.item = '0;
      j.cap  = '0;
      j.gaps = gaps_on;
      jobs.push_back(j);
   endtask

   // One capacity setting followed by runs that lean towards filling or
   // draining, so both full and empty are reached often; a fifth of the
   // items are any operation at all.
   task automatic queue_phase(input int c, input int n_items);
      int       left;
      int       run;
      bit       fill_up;
      func_type f;
      queue_cap(c);
      left = n_items;
      while (left > 0) begin
         run     = $urandom_range(1, 2 * c + 2);
         fill_up = $urandom_range(0, 1);
         for (int k = 0; k < run && left > 0; k++) begin
            if ($urandom_range(0, 4) == 0)
               f = func_type'($urandom_range(0, 3));
            else if (fill_up)
               f = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK;
            else
               f = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK;
            queue_item(f, rand_word());
            left--;
         end
         if ($urandom_range(0, 9) == 0)
            queue_settle();   // sender holds off until the block has caught up
      end
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      // Directed, capacity 16 straight out of reset: both pops on an empty deque,
      // front push into empty, front pointer wrapping below slot 0, drain both ends.
      queue_item(FUNC_POP_BACK,   32'h0000_0000);
      queue_item(FUNC_POP_FRONT,  32'hFFFF_FFFF);
      queue_item(FUNC_PUSH_FRONT, 32'hFFFF_FFFF);
      queue_item(FUNC_PUSH_BACK,  32'h0000_0000);
      queue_item(FUNC_PUSH_FRONT, 32'hA5A5_A5A5);
      queue_item(FUNC_PUSH_BACK,  32'h5A5A_5A5A);
      queue_item(FUNC_POP_FRONT,  32'h1111_1111);
      queue_item(FUNC_POP_BACK,   32'h2222_2222);
      queue_item(FUNC_POP_BACK,   32'h3333_3333);
      queue_item(FUNC_POP_BACK,   32'h4444_4444);
      queue_settle();
      // Capacity 1: overflow on both pushes, front push into empty wraps back to 0
      queue_cap(1);
      queue_item(FUNC_PUSH_BACK,  32'h1234_5678);
      queue_item(FUNC_PUSH_BACK,  32'hDEAD_BEEF);
      queue_item(FUNC_PUSH_FRONT, 32'hCAFE_F00D);
      queue_item(FUNC_POP_FRONT,  32'h0000_0000);
      queue_item(FUNC_PUSH_FRONT, 32'h8765_4321);
      queue_item(FUNC_POP_BACK,   32'h0000_0000);
      queue_item(FUNC_POP_BACK,   32'h0000_0000);
      // Capacity 2: fill, overflow, front pointer wrap, drain to underflow
      queue_cap(2);
      queue_item(FUNC_PUSH_BACK,  32'h0000_0001);
      queue_item(FUNC_PUSH_FRONT, 32'h8000_0000);
      queue_item(FUNC_PUSH_BACK,  32'hFFFF_FFFE);
      queue_item(FUNC_POP_BACK,   32'h0000_0000);
      queue_item(FUNC_PUSH_BACK,  32'h7FFF_FFFF);
      queue_item(FUNC_POP_FRONT,  32'h0000_0000);
      queue_item(FUNC_POP_FRONT,  32'h0000_0000);
      queue_item(FUNC_POP_FRONT,  32'h0000_0000);

      // Random phases; one stretch without idling mid-run and none at the end
      queue_phase(16, 50);
      queue_phase(1, 40);
      queue_phase(2, 45);
      gaps_on = 1'b0;
      queue_phase($urandom_range(3, 15), 45);
      gaps_on = 1'b1;
      queue_phase(16, 55);
      queue_phase($urandom_range(3, 8), 45);
      queue_phase(15, 45);
      gaps_on = 1'b0;
      queue_phase($urandom_range(1, 16), 45);
      queue_phase(16, 50);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (!all_sent || owed_results.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (miss_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
